// File: src/assert_macros.svh
// Assertion helpers for the RTL. Both expect clk in scope; ASSERT_CLK_RST also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/drt_pkg.sv
package drt_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 200;

    localparam int COORD_W  = 9;   // box corner width
    localparam int ROW_W    = 10;  // reported row width
    localparam int OFFSET_W = 8;
    localparam int RECT_W   = 16;

    localparam logic [OFFSET_W-1:0] ROW_OFFSET_RESET = 8'd20;

    typedef enum logic {
        KIND_ADD     = 1'b0,
        KIND_PRESENT = 1'b1
    } kind_t;

endpackage

// File: src/drt_if.sv
interface drt_in_if;
    import drt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [RECT_W-1:0] rect_x;
    logic signed [RECT_W-1:0] rect_y;
    logic signed [RECT_W-1:0] rect_w;
    logic signed [RECT_W-1:0] rect_h;

    modport source (output valid, kind, rect_x, rect_y, rect_w, rect_h, input ready);
    modport sink   (input valid, kind, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface drt_out_if;
    import drt_pkg::*;

    logic               valid;
    logic               ready;
    logic               window_valid;
    logic [COORD_W-1:0] win_left;
    logic [ROW_W-1:0]   win_top;
    logic [COORD_W-1:0] win_right;
    logic [ROW_W-1:0]   win_bottom;

    modport source (output valid, window_valid, win_left, win_top, win_right, win_bottom,
                    input ready);
    modport sink   (input valid, window_valid, win_left, win_top, win_right, win_bottom,
                    output ready);
endinterface

// File: src/dirty_region_tracker_core.sv
// Dirty region tracker.
// cmd (valid/ready): one beat per drawing event. kind = add carries a signed
//   rectangle that is clipped to the screen and merged into the bounding box;
//   kind = present reports the box and clears it.
// win (valid/ready): one beat per present beat, none per add beat.
//   window_valid = 0 with all corners zero means nothing changed.
// cfg_we/cfg_wdata: row_offset, added to the reported top and bottom rows;
//   write it only while the block is idle.
// A present beat goes through the cmd register, then the result register, to win.
// Throughput: one cmd beat per cycle unless a present beat waits for win; the
//   clip and min/max merge sit between the cmd register and the box registers.
// A stalled win holds its beat; cmd keeps accepting add beats and one more
//   present beat, which then waits in the cmd register until win frees up.
// Reset (rst_n low, async): box empty, row_offset = 20, both channels idle.
module dirty_region_tracker_core #(
    parameter int SCREEN_WIDTH  = drt_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = drt_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [drt_pkg::OFFSET_W-1:0]  cfg_wdata,
    drt_in_if.sink                        cmd,
    drt_out_if.source                     win
);
    import drt_pkg::*;

    `include "assert_macros.svh"

    localparam logic signed [19:0] WIDTH_LIM  = 20'(SCREEN_WIDTH);
    localparam logic signed [19:0] HEIGHT_LIM = 20'(SCREEN_HEIGHT);

    typedef struct packed {
        logic               empty;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } span_t;

    // Clip one axis to [0, limit); hi is inclusive.
    function automatic span_t clip_span(input logic signed [RECT_W-1:0] pos,
                                        input logic signed [RECT_W-1:0] len,
                                        input logic signed [19:0]       limit);
        logic signed [19:0] pos_ext;
        logic signed [19:0] len_ext;
        logic signed [19:0] first;
        logic signed [19:0] span_len;
        logic signed [19:0] stop;
        logic signed [19:0] last;
        span_t              s;
        pos_ext = $signed({{4{pos[RECT_W-1]}}, pos});
        len_ext = $signed({{4{len[RECT_W-1]}}, len});
        if (pos_ext < 20'sd0)
        begin
            first    = 20'sd0;
            span_len = len_ext + pos_ext;
        end
        else
        begin
            first    = pos_ext;
            span_len = len_ext;
        end
        stop = first + span_len;
        if (stop > limit)
            stop = limit;
        last    = stop - 20'sd1;
        s.empty = (stop <= first);
        s.lo    = first[COORD_W-1:0];
        s.hi    = last[COORD_W-1:0];
        return s;
    endfunction

    // cmd register
    logic                     cmd_valid_reg;
    kind_t                    kind_reg;
    logic signed [RECT_W-1:0] x_reg, y_reg, w_reg, h_reg;

    // bounding box
    logic               empty_reg, empty_next;
    logic [COORD_W-1:0] box_left_reg, box_left_next;
    logic [COORD_W-1:0] box_top_reg, box_top_next;
    logic [COORD_W-1:0] box_right_reg, box_right_next;
    logic [COORD_W-1:0] box_bottom_reg, box_bottom_next;

    logic [OFFSET_W-1:0] row_offset_reg;

    // result register
    logic               rsp_valid_reg;
    logic               rsp_window_reg, rsp_window_next;
    logic [COORD_W-1:0] rsp_left_reg, rsp_left_next;
    logic [ROW_W-1:0]   rsp_top_reg, rsp_top_next;
    logic [COORD_W-1:0] rsp_right_reg, rsp_right_next;
    logic [ROW_W-1:0]   rsp_bottom_reg, rsp_bottom_next;

    span_t span_x, span_y;
    logic  rsp_free, stage_fire, add_fire, present_fire, rect_hit;

    always_comb
    begin
        span_x       = clip_span(x_reg, w_reg, WIDTH_LIM);
        span_y       = clip_span(y_reg, h_reg, HEIGHT_LIM);
        rsp_free     = !rsp_valid_reg || win.ready;
        stage_fire   = cmd_valid_reg && (kind_reg == KIND_ADD || rsp_free);
        add_fire     = stage_fire && kind_reg == KIND_ADD;
        present_fire = stage_fire && kind_reg == KIND_PRESENT;
        rect_hit     = !span_x.empty && !span_y.empty;

        empty_next      = empty_reg;
        box_left_next   = box_left_reg;
        box_top_next    = box_top_reg;
        box_right_next  = box_right_reg;
        box_bottom_next = box_bottom_reg;
        if (add_fire && rect_hit)
        begin
            empty_next = 1'b0;
            if (empty_reg)
            begin
                box_left_next   = span_x.lo;
                box_top_next    = span_y.lo;
                box_right_next  = span_x.hi;
                box_bottom_next = span_y.hi;
            end
            else
            begin
                if (span_x.lo < box_left_reg)   box_left_next   = span_x.lo;
                if (span_y.lo < box_top_reg)    box_top_next    = span_y.lo;
                if (span_x.hi > box_right_reg)  box_right_next  = span_x.hi;
                if (span_y.hi > box_bottom_reg) box_bottom_next = span_y.hi;
            end
        end
        else if (present_fire)
        begin
            empty_next = 1'b1;
        end

        rsp_window_next = !empty_reg;
        if (empty_reg)
        begin
            rsp_left_next   = '0;
            rsp_top_next    = '0;
            rsp_right_next  = '0;
            rsp_bottom_next = '0;
        end
        else
        begin
            rsp_left_next   = box_left_reg;
            rsp_top_next    = {1'b0, box_top_reg} + {2'b00, row_offset_reg};
            rsp_right_next  = box_right_reg;
            rsp_bottom_next = {1'b0, box_bottom_reg} + {2'b00, row_offset_reg};
        end
    end

    assign cmd.ready        = !cmd_valid_reg || stage_fire;
    assign win.valid        = rsp_valid_reg;
    assign win.window_valid = rsp_window_reg;
    assign win.win_left     = rsp_left_reg;
    assign win.win_top      = rsp_top_reg;
    assign win.win_right    = rsp_right_reg;
    assign win.win_bottom   = rsp_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg  <= 1'b0;
            empty_reg      <= 1'b1;
            rsp_valid_reg  <= 1'b0;
            row_offset_reg <= ROW_OFFSET_RESET;
        end
        else
        begin
            if (cmd.ready)
                cmd_valid_reg <= cmd.valid;
            empty_reg <= empty_next;
            if (present_fire)
                rsp_valid_reg <= 1'b1;
            else if (win.ready)
                rsp_valid_reg <= 1'b0;
            if (cfg_we)
                row_offset_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            kind_reg <= kind_t'(cmd.kind);
            x_reg    <= cmd.rect_x;
            y_reg    <= cmd.rect_y;
            w_reg    <= cmd.rect_w;
            h_reg    <= cmd.rect_h;
        end
        box_left_reg   <= box_left_next;
        box_top_reg    <= box_top_next;
        box_right_reg  <= box_right_next;
        box_bottom_reg <= box_bottom_next;
        if (present_fire)
        begin
            rsp_window_reg <= rsp_window_next;
            rsp_left_reg   <= rsp_left_next;
            rsp_top_reg    <= rsp_top_next;
            rsp_right_reg  <= rsp_right_next;
            rsp_bottom_reg <= rsp_bottom_next;
        end
    end

    `ASSERT_CLK_RST(a_present_clears, present_fire |=> empty_reg,
        "box not cleared after present beat")
    `ASSERT_CLK_RST(a_no_overwrite, present_fire |-> (!rsp_valid_reg || win.ready),
        "result register overwritten while stalled")
    `ASSERT_CLK(a_box_ordered,
        !empty_reg |-> (box_left_reg <= box_right_reg && box_top_reg <= box_bottom_reg),
        "dirty box corners out of order")
    `ASSERT_CLK_RST(a_empty_window_zero,
        (rsp_valid_reg && !rsp_window_reg) |->
            (rsp_left_reg == '0 && rsp_top_reg == '0 &&
             rsp_right_reg == '0 && rsp_bottom_reg == '0),
        "empty window reports nonzero corners")

endmodule
